// ----- src/heater_thermostat_controller_assert.svh -----
// Assertion macros used by the heater thermostat controller port checker
`ifndef HEATER_THERMOSTAT_CONTROLLER_ASSERT_SVH
`define HEATER_THERMOSTAT_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define HTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("htc check failed: same-cycle implication");

// Next-cycle implication, checked out of reset
`define HTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("htc check failed: next-cycle implication");

`endif

// ----- src/htc_pkg.sv -----
// Shared types, codes and helpers for the heater thermostat controller
package htc_pkg;

    // Field widths
    localparam int TEMP_W   = 12;
    localparam int CALC_W   = 14;
    localparam int DEG_W    = 7;
    localparam int TIMER_W  = 16;
    localparam int DIGIT_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Command codes
    localparam logic [1:0] CMD_KEY    = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // Key codes (ASCII)
    localparam logic [7:0] KEY_A    = 8'h41;
    localparam logic [7:0] KEY_C    = 8'h43;
    localparam logic [7:0] KEY_HASH = 8'h23;
    localparam logic [7:0] KEY_0    = 8'h30;
    localparam logic [7:0] KEY_9    = 8'h39;

    // Entry status codes
    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_COUNT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REHEAT    = 3'd4;

    // Configuration reset values
    localparam logic [7:0]         TOL_RST    = 8'd64;
    localparam logic [TIMER_W-1:0] DWELL_RST  = 16'd5000;
    localparam logic [DEG_W-1:0]   MAXDEG_RST = 7'd125;
    localparam logic [4:0]         MARGIN_RST = 5'd5;
    localparam logic [7:0]         REHEAT_RST = 8'd8;

    // Timer saturation value and digit limits
    localparam logic [TIMER_W-1:0] TIMER_MAX  = 16'hFFFF;
    localparam logic [1:0]         DIGIT_MAX  = 2'd3;
    localparam logic [1:0]         DIGIT_MIN  = 2'd2;

    // Operating mode, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_HEAT  = 5'b00010,
        MODE_STAB  = 5'b00100,
        MODE_REACH = 5'b01000,
        MODE_OVER  = 5'b10000
    } mode_t;

    // Mode codes as seen on the result channel
    localparam logic [2:0] MODE_CODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_CODE_HEAT  = 3'd1;
    localparam logic [2:0] MODE_CODE_STAB  = 3'd2;
    localparam logic [2:0] MODE_CODE_REACH = 3'd3;
    localparam logic [2:0] MODE_CODE_OVER  = 3'd4;

    typedef struct packed {
        logic [7:0]         tolerance;
        logic [TIMER_W-1:0] dwell_ms;
        logic [DEG_W-1:0]   max_degrees;
        logic [4:0]         recover_margin;
        logic [7:0]         reheat_band;
    } cfg_t;

    typedef struct packed {
        logic [1:0]               command;
        logic [7:0]               key_code;
        logic signed [TEMP_W-1:0] sample;
        logic                     sample_valid;
    } item_t;

    typedef struct packed {
        logic             heater_on;
        logic [7:0]       servo_angle;
        logic [2:0]       mode;
        logic [DEG_W-1:0] target_out;
        logic [1:0]       entry_status;
        logic             entering;
    } result_t;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] code;
        case (m)
            MODE_IDLE:  code = MODE_CODE_IDLE;
            MODE_HEAT:  code = MODE_CODE_HEAT;
            MODE_STAB:  code = MODE_CODE_STAB;
            MODE_REACH: code = MODE_CODE_REACH;
            MODE_OVER:  code = MODE_CODE_OVER;
            default:    code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

    // Whole degrees to signed sixteenths
    function automatic logic signed [CALC_W-1:0] deg16(input logic [DEG_W-1:0] d);
        return signed'({3'b000, d, 4'b0000});
    endfunction

    // Sign-extend a temperature to calculation width
    function automatic logic signed [CALC_W-1:0] temp_ext(input logic signed [TEMP_W-1:0] t);
        return signed'({{(CALC_W-TEMP_W){t[TEMP_W-1]}}, t});
    endfunction

    // Unsigned 8-bit band to calculation width
    function automatic logic signed [CALC_W-1:0] band_ext(input logic [7:0] b);
        return signed'({6'b000000, b});
    endfunction

    function automatic logic below_band(input logic signed [CALC_W-1:0] t,
                                        input logic signed [CALC_W-1:0] tgt,
                                        input logic [7:0] tol);
        return t < (tgt - band_ext(tol));
    endfunction

    function automatic logic in_band(input logic signed [CALC_W-1:0] t,
                                     input logic signed [CALC_W-1:0] tgt,
                                     input logic [7:0] tol);
        return (t >= (tgt - band_ext(tol))) && (t <= (tgt + band_ext(tol)));
    endfunction

endpackage

// ----- src/htc_cfg_regs.sv -----
// Configuration register file for the heater thermostat controller
module htc_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [htc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [htc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output htc_pkg::cfg_t                     cfg
);

    htc_pkg::cfg_t cfg_reg;
    htc_pkg::cfg_t cfg_next;

    // Always ready for a write
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the write; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                htc_pkg::CFG_TOLERANCE: cfg_next.tolerance      = cfg_data[7:0];
                htc_pkg::CFG_DWELL:     cfg_next.dwell_ms       = cfg_data;
                htc_pkg::CFG_MAX_DEG:   cfg_next.max_degrees    = cfg_data[htc_pkg::DEG_W-1:0];
                htc_pkg::CFG_MARGIN:    cfg_next.recover_margin = cfg_data[4:0];
                htc_pkg::CFG_REHEAT:    cfg_next.reheat_band    = cfg_data[7:0];
                default:                cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tolerance      <= htc_pkg::TOL_RST;
            cfg_reg.dwell_ms       <= htc_pkg::DWELL_RST;
            cfg_reg.max_degrees    <= htc_pkg::MAXDEG_RST;
            cfg_reg.recover_margin <= htc_pkg::MARGIN_RST;
            cfg_reg.reheat_band    <= htc_pkg::REHEAT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/htc_ctrl_core.sv -----
// Controller state and single-pass update logic for one transaction
module htc_ctrl_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  htc_pkg::item_t   item,
    input  htc_pkg::cfg_t    cfg,
    output htc_pkg::result_t result
);

    htc_pkg::mode_t                        mode_reg, mode_next;
    logic                                  heater_reg, heater_next;
    logic [7:0]                            servo_reg, servo_next;
    logic [htc_pkg::DEG_W-1:0]             target_reg, target_next;
    logic                                  running_reg, running_next;
    logic                                  entry_active_reg, entry_active_next;
    logic [htc_pkg::DIGIT_W-1:0]           digit_value_reg, digit_value_next;
    logic [1:0]                            digit_count_reg, digit_count_next;
    logic signed [htc_pkg::TEMP_W-1:0]     temperature_reg, temperature_next;
    logic [htc_pkg::TIMER_W-1:0]           mode_timer_reg, mode_timer_next;

    logic [1:0]                            status;
    logic signed [htc_pkg::CALC_W-1:0]     t_cur;
    logic signed [htc_pkg::CALC_W-1:0]     t_old;
    logic signed [htc_pkg::CALC_W-1:0]     tgt16;
    logic signed [htc_pkg::CALC_W-1:0]     tgt16_entry;
    logic signed [htc_pkg::CALC_W-1:0]     max16;
    logic signed [htc_pkg::CALC_W-1:0]     recover16;
    logic [3:0]                            digit;
    logic [htc_pkg::CALC_W-1:0]            digit_sum;

    // Operands for the compares
    always_comb begin
        t_old = htc_pkg::temp_ext(temperature_reg);
        t_cur = htc_pkg::temp_ext(
                    (item.command == htc_pkg::CMD_SAMPLE && item.sample_valid) ?
                    item.sample : temperature_reg);
        tgt16 = htc_pkg::deg16(target_reg);
        tgt16_entry = htc_pkg::deg16(digit_value_reg[htc_pkg::DEG_W-1:0]);
        max16 = htc_pkg::deg16(cfg.max_degrees);
        recover16 = max16 - signed'({5'b00000, cfg.recover_margin, 4'b0000});
        digit = 4'(item.key_code - htc_pkg::KEY_0);
        digit_sum = {digit_value_reg, 3'b000} + {3'b000, digit_value_reg, 1'b0}
                    + {10'd0, digit};
    end

    // Next state for the transaction
    always_comb begin
        mode_next         = mode_reg;
        heater_next       = heater_reg;
        servo_next        = servo_reg;
        target_next       = target_reg;
        running_next      = running_reg;
        entry_active_next = entry_active_reg;
        digit_value_next  = digit_value_reg;
        digit_count_next  = digit_count_reg;
        temperature_next  = temperature_reg;
        mode_timer_next   = mode_timer_reg;
        status            = htc_pkg::ST_NONE;

        if (item.command == htc_pkg::CMD_SAMPLE && item.sample_valid) begin
            temperature_next = item.sample;
        end

        case (item.command)
            htc_pkg::CMD_KEY: begin
                if (item.key_code == htc_pkg::KEY_A) begin
                    entry_active_next = 1'b1;
                    digit_value_next  = '0;
                    digit_count_next  = '0;
                end else if (item.key_code == htc_pkg::KEY_C) begin
                    running_next      = 1'b0;
                    target_next       = '0;
                    heater_next       = 1'b0;
                    servo_next        = '0;
                    entry_active_next = 1'b0;
                    mode_next         = htc_pkg::MODE_IDLE;
                end else if (item.key_code == htc_pkg::KEY_HASH && entry_active_reg) begin
                    if (digit_count_reg < htc_pkg::DIGIT_MIN) begin
                        digit_value_next = '0;
                        digit_count_next = '0;
                        status           = htc_pkg::ST_COUNT;
                    end else if (digit_value_reg == '0 ||
                                 digit_value_reg > {3'b000, cfg.max_degrees}) begin
                        digit_value_next = '0;
                        digit_count_next = '0;
                        status           = htc_pkg::ST_RANGE;
                    end else begin
                        target_next       = digit_value_reg[htc_pkg::DEG_W-1:0];
                        running_next      = 1'b1;
                        entry_active_next = 1'b0;
                        if (htc_pkg::below_band(t_old, tgt16_entry, cfg.tolerance)) begin
                            mode_next = htc_pkg::MODE_HEAT;
                        end else if (htc_pkg::in_band(t_old, tgt16_entry, cfg.tolerance)) begin
                            mode_next = htc_pkg::MODE_STAB;
                        end
                    end
                end else if (entry_active_reg && item.key_code >= htc_pkg::KEY_0 &&
                             item.key_code <= htc_pkg::KEY_9) begin
                    if (digit_count_reg < htc_pkg::DIGIT_MAX) begin
                        digit_value_next = digit_sum[htc_pkg::DIGIT_W-1:0];
                        digit_count_next = digit_count_reg + 2'd1;
                    end
                end
            end

            htc_pkg::CMD_SAMPLE: begin
                // Drive heater and servo from the mode held before this sample
                if (mode_reg == htc_pkg::MODE_OVER || !running_reg || target_reg == '0) begin
                    heater_next = 1'b0;
                    servo_next  = '0;
                end else begin
                    case (mode_reg)
                        htc_pkg::MODE_HEAT: begin
                            heater_next = 1'b1;
                            servo_next  = {1'b0, target_reg};
                        end
                        htc_pkg::MODE_STAB: begin
                            if (t_cur < tgt16) begin
                                heater_next = 1'b1;
                                servo_next  = {1'b0, target_reg};
                            end else begin
                                heater_next = 1'b0;
                            end
                        end
                        htc_pkg::MODE_REACH: begin
                            if (t_cur < tgt16 - htc_pkg::band_ext(cfg.reheat_band)) begin
                                heater_next = 1'b1;
                            end else if (t_cur >= tgt16) begin
                                heater_next = 1'b0;
                            end
                            servo_next = {1'b0, target_reg};
                        end
                        default: begin
                            heater_next = 1'b0;
                            servo_next  = '0;
                        end
                    endcase
                end

                // Advance the mode machine
                if (t_cur >= max16) begin
                    mode_next = htc_pkg::MODE_OVER;
                end else if (!running_reg || target_reg == '0) begin
                    mode_next = htc_pkg::MODE_IDLE;
                end else if (t_cur > tgt16 + htc_pkg::band_ext(cfg.tolerance)) begin
                    mode_next = htc_pkg::MODE_IDLE;
                end else begin
                    case (mode_reg)
                        htc_pkg::MODE_IDLE: begin
                            if (htc_pkg::below_band(t_cur, tgt16, cfg.tolerance)) begin
                                mode_next = htc_pkg::MODE_HEAT;
                            end else if (htc_pkg::in_band(t_cur, tgt16, cfg.tolerance)) begin
                                mode_next = htc_pkg::MODE_REACH;
                            end
                        end
                        htc_pkg::MODE_HEAT: begin
                            if (htc_pkg::in_band(t_cur, tgt16, cfg.tolerance)) begin
                                mode_next = htc_pkg::MODE_STAB;
                            end
                        end
                        htc_pkg::MODE_STAB: begin
                            if (mode_timer_reg >= cfg.dwell_ms &&
                                htc_pkg::in_band(t_cur, tgt16, cfg.tolerance)) begin
                                mode_next = htc_pkg::MODE_REACH;
                            end else if (htc_pkg::below_band(t_cur, tgt16, cfg.tolerance)) begin
                                mode_next = htc_pkg::MODE_HEAT;
                            end
                        end
                        htc_pkg::MODE_REACH: begin
                            if (htc_pkg::below_band(t_cur, tgt16, cfg.tolerance)) begin
                                mode_next = htc_pkg::MODE_HEAT;
                            end
                        end
                        htc_pkg::MODE_OVER: begin
                            if (t_cur < recover16) begin
                                if (htc_pkg::in_band(t_cur, tgt16, cfg.tolerance)) begin
                                    mode_next = htc_pkg::MODE_REACH;
                                end else if (htc_pkg::below_band(t_cur, tgt16,
                                                                 cfg.tolerance)) begin
                                    mode_next = htc_pkg::MODE_HEAT;
                                end else begin
                                    mode_next = htc_pkg::MODE_IDLE;
                                end
                            end
                        end
                        default: mode_next = mode_reg;
                    endcase
                end
            end

            htc_pkg::CMD_TICK: begin
                if (mode_timer_reg != htc_pkg::TIMER_MAX) begin
                    mode_timer_next = mode_timer_reg + 16'd1;
                end
            end

            default: begin
                mode_next = mode_reg;
            end
        endcase

        // Restart the timer on a real mode change
        if (mode_next != mode_reg) begin
            mode_timer_next = '0;
        end
    end

    // Result fields follow the updated state
    always_comb begin
        result.heater_on    = heater_next;
        result.servo_angle  = servo_next;
        result.mode         = htc_pkg::mode_code(mode_next);
        result.target_out   = target_next;
        result.entry_status = status;
        result.entering     = entry_active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= htc_pkg::MODE_IDLE;
            heater_reg       <= 1'b0;
            servo_reg        <= '0;
            target_reg       <= '0;
            running_reg      <= 1'b0;
            entry_active_reg <= 1'b0;
            digit_value_reg  <= '0;
            digit_count_reg  <= '0;
            temperature_reg  <= '0;
            mode_timer_reg   <= '0;
        end else if (step_en) begin
            mode_reg         <= mode_next;
            heater_reg       <= heater_next;
            servo_reg        <= servo_next;
            target_reg       <= target_next;
            running_reg      <= running_next;
            entry_active_reg <= entry_active_next;
            digit_value_reg  <= digit_value_next;
            digit_count_reg  <= digit_count_next;
            temperature_reg  <= temperature_next;
            mode_timer_reg   <= mode_timer_next;
        end
    end

endmodule

// ----- src/heater_thermostat_controller.sv -----
// Heater thermostat controller top level: input stage, control core, result stage
//
// Usage:
//   s_ channel carries one transaction per keypad key, temperature sample or
//   millisecond tick (s_command selects which). Every accepted transaction
//   yields exactly one result on the m_ channel: heater level, servo angle,
//   mode, target, entry status and entry flag after that transaction.
//   cfg_ channel writes the five control registers by index; it is always
//   ready and should only be written while no transaction is in flight.
// Timing:
//   An accepted transaction passes the input register, then the result
//   register; its result is valid once the result register loads.
//   One transaction per cycle is sustained while m_ready stays high; the core
//   state updates in the same cycle the result register loads.
// Reset (aresetn low, synchronous): control registers return to their defaults, the
//   controller goes idle with target zero, and both stages empty.
// Back-pressure: while m_ready is low the result holds; one more transaction
//   is taken into the input register, then s_ready drops until the result
//   is taken.
module heater_thermostat_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_command,
    input  logic [7:0]                        s_key_code,
    input  logic signed [htc_pkg::TEMP_W-1:0] s_sample,
    input  logic                              s_sample_valid,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_heater_on,
    output logic [7:0]                        m_servo_angle,
    output logic [2:0]                        m_mode,
    output logic [htc_pkg::DEG_W-1:0]         m_target_out,
    output logic [1:0]                        m_entry_status,
    output logic                              m_entering,
    // configuration channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [htc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [htc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    htc_pkg::cfg_t    cfg;
    htc_pkg::item_t   item_reg;
    htc_pkg::result_t core_result;
    htc_pkg::result_t result_reg;
    logic             in_valid_reg, in_valid_next;
    logic             m_valid_reg, m_valid_next;
    logic             advance;
    logic             s_take;

    htc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    htc_ctrl_core u_ctrl_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // Move the held transaction into the result stage when it has room
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = advance || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            item_reg.command      <= s_command;
            item_reg.key_code     <= s_key_code;
            item_reg.sample       <= s_sample;
            item_reg.sample_valid <= s_sample_valid;
        end
        if (advance) begin
            result_reg <= core_result;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_heater_on    = result_reg.heater_on;
    assign m_servo_angle  = result_reg.servo_angle;
    assign m_mode         = result_reg.mode;
    assign m_target_out   = result_reg.target_out;
    assign m_entry_status = result_reg.entry_status;
    assign m_entering     = result_reg.entering;

endmodule

// ----- src/htc_port_checker.sv -----
// Port-level checks for the heater thermostat controller, bound to the top level
`include "heater_thermostat_controller_assert.svh"

module htc_port_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_heater_on,
    input logic [7:0]                m_servo_angle,
    input logic [2:0]                m_mode,
    input logic [htc_pkg::DEG_W-1:0] m_target_out,
    input logic [1:0]                m_entry_status,
    input logic                      m_entering
);

    // Stalled result stays and holds its payload
    `HTC_ASSERT_NXT(a_result_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_heater_on) && $stable(m_servo_angle) && $stable(m_mode) &&
        $stable(m_target_out) && $stable(m_entry_status) && $stable(m_entering))

    // Heater can only be driven with a target set
    `HTC_ASSERT_IMP(a_heater_needs_target, aclk, aresetn, m_valid && m_heater_on,
        m_target_out != '0)

    // A rejected entry leaves entry in progress
    `HTC_ASSERT_IMP(a_reject_keeps_entry, aclk, aresetn,
        m_valid && m_entry_status != htc_pkg::ST_NONE, m_entering)

    // Without a target the controller is idle or in overheat
    `HTC_ASSERT_IMP(a_no_target_idle, aclk, aresetn, m_valid && m_target_out == '0,
        m_mode == htc_pkg::MODE_CODE_IDLE || m_mode == htc_pkg::MODE_CODE_OVER)

endmodule

bind heater_thermostat_controller htc_port_checker u_htc_port_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_heater_on    (m_heater_on),
    .m_servo_angle  (m_servo_angle),
    .m_mode         (m_mode),
    .m_target_out   (m_target_out),
    .m_entry_status (m_entry_status),
    .m_entering     (m_entering)
);

// ----- sim/heater_thermostat_controller_test.sv -----
// Self-checking testbench for the heater thermostat controller
`timescale 1ns / 1ps

module heater_thermostat_controller_test;

    // Field widths taken from the shared package
    localparam int TEMP_W     = htc_pkg::TEMP_W;
    localparam int DEG_W      = htc_pkg::DEG_W;
    localparam int TIMER_W    = htc_pkg::TIMER_W;
    localparam int DIGIT_W    = htc_pkg::DIGIT_W;
    localparam int CFG_IDX_W  = htc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = htc_pkg::CFG_DATA_W;

    // Command code with no function in the block
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Longest run of cycles with no transaction on any channel
    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 90;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_command      = htc_pkg::CMD_KEY;
    logic [7:0]               s_key_code     = 8'd0;
    logic signed [TEMP_W-1:0] s_sample       = '0;
    logic                     s_sample_valid = 1'b0;

    logic             m_valid;
    logic             m_ready = 1'b0;
    logic             m_heater_on;
    logic [7:0]       m_servo_angle;
    logic [2:0]       m_mode;
    logic [DEG_W-1:0] m_target_out;
    logic [1:0]       m_entry_status;
    logic             m_entering;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = htc_pkg::CFG_TOLERANCE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    heater_thermostat_controller u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_key_code     (s_key_code),
        .s_sample       (s_sample),
        .s_sample_valid (s_sample_valid),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_heater_on    (m_heater_on),
        .m_servo_angle  (m_servo_angle),
        .m_mode         (m_mode),
        .m_target_out   (m_target_out),
        .m_entry_status (m_entry_status),
        .m_entering     (m_entering),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Thermostat model state
    logic [7:0]         cfg_tol;
    logic [TIMER_W-1:0] cfg_dwell;
    logic [DEG_W-1:0]   cfg_maxdeg;
    logic [4:0]         cfg_margin;
    logic [7:0]         cfg_reheat;

    logic [2:0]         mode_q;
    logic               heat_q;
    logic [7:0]         servo_q;
    logic [DEG_W-1:0]   tgt_q;
    logic               run_q;
    logic               entry_q;
    logic [DIGIT_W-1:0] dig_val;
    logic [1:0]         dig_cnt;
    int                 temp_q;
    logic [TIMER_W-1:0] mode_ms;

    htc_pkg::result_t predicted_outputs[$];
    int               mismatch_count = 0;
    int               items_sent     = 0;
    int               quiet_cycles   = 0;
    bit               no_idle        = 1'b0;

    // Free-running clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void thermostat_reset();
        cfg_tol    = htc_pkg::TOL_RST;
        cfg_dwell  = htc_pkg::DWELL_RST;
        cfg_maxdeg = htc_pkg::MAXDEG_RST;
        cfg_margin = htc_pkg::MARGIN_RST;
        cfg_reheat = htc_pkg::REHEAT_RST;
        mode_q     = htc_pkg::MODE_CODE_IDLE;
        heat_q     = 1'b0;
        servo_q    = 8'd0;
        tgt_q      = '0;
        run_q      = 1'b0;
        entry_q    = 1'b0;
        dig_val    = '0;
        dig_cnt    = 2'd0;
        temp_q     = 0;
        mode_ms    = '0;
    endfunction

    function automatic int target_x16();
        return int'(tgt_q) * 16;
    endfunction

    function automatic bit below_window();
        return temp_q < target_x16() - int'(cfg_tol);
    endfunction

    function automatic bit within_window();
        return temp_q >= target_x16() - int'(cfg_tol) &&
               temp_q <= target_x16() + int'(cfg_tol);
    endfunction

    // Restart the mode timer only on a real mode change
    function automatic void switch_mode(input logic [2:0] m);
        if (m != mode_q) begin
            mode_q  = m;
            mode_ms = '0;
        end
    endfunction

    // Advance the thermostat by one transaction and return its outputs
    function automatic htc_pkg::result_t thermostat_step(input htc_pkg::item_t it);
        htc_pkg::result_t r;
        logic [1:0] status;
        logic [7:0] k;
        status = htc_pkg::ST_NONE;
        k = it.key_code;
        case (it.command)
            htc_pkg::CMD_KEY: begin
                if (k == htc_pkg::KEY_A) begin
                    entry_q = 1'b1;
                    dig_val = '0;
                    dig_cnt = 2'd0;
                end else if (k == htc_pkg::KEY_C) begin
                    run_q   = 1'b0;
                    tgt_q   = '0;
                    heat_q  = 1'b0;
                    servo_q = 8'd0;
                    entry_q = 1'b0;
                    switch_mode(htc_pkg::MODE_CODE_IDLE);
                end else if (k == htc_pkg::KEY_HASH && entry_q) begin
                    if (dig_cnt < htc_pkg::DIGIT_MIN) begin
                        dig_val = '0;
                        dig_cnt = 2'd0;
                        status  = htc_pkg::ST_COUNT;
                    end else if (dig_val == 0 || dig_val > cfg_maxdeg) begin
                        dig_val = '0;
                        dig_cnt = 2'd0;
                        status  = htc_pkg::ST_RANGE;
                    end else begin
                        tgt_q   = dig_val[DEG_W-1:0];
                        run_q   = 1'b1;
                        entry_q = 1'b0;
                        if (below_window())
                            switch_mode(htc_pkg::MODE_CODE_HEAT);
                        else if (within_window())
                            switch_mode(htc_pkg::MODE_CODE_STAB);
                    end
                end else if (entry_q && k >= htc_pkg::KEY_0 && k <= htc_pkg::KEY_9) begin
                    // drop any digit past the third
                    if (dig_cnt < htc_pkg::DIGIT_MAX) begin
                        dig_val = DIGIT_W'(dig_val * 10 + (k - htc_pkg::KEY_0));
                        dig_cnt = dig_cnt + 2'd1;
                    end
                end
            end
            htc_pkg::CMD_SAMPLE: begin
                if (it.sample_valid)
                    temp_q = it.sample;
                // drive heater and servo from the mode held before this sample
                if (mode_q == htc_pkg::MODE_CODE_OVER || !run_q || tgt_q == 0) begin
                    heat_q  = 1'b0;
                    servo_q = 8'd0;
                end else begin
                    case (mode_q)
                        htc_pkg::MODE_CODE_HEAT: begin
                            heat_q  = 1'b1;
                            servo_q = {1'b0, tgt_q};
                        end
                        htc_pkg::MODE_CODE_STAB: begin
                            if (temp_q < target_x16()) begin
                                heat_q  = 1'b1;
                                servo_q = {1'b0, tgt_q};
                            end else begin
                                heat_q = 1'b0;
                            end
                        end
                        htc_pkg::MODE_CODE_REACH: begin
                            if (temp_q < target_x16() - int'(cfg_reheat))
                                heat_q = 1'b1;
                            else if (temp_q >= target_x16())
                                heat_q = 1'b0;
                            servo_q = {1'b0, tgt_q};
                        end
                        default: begin
                            heat_q  = 1'b0;
                            servo_q = 8'd0;
                        end
                    endcase
                end
                // then move the mode machine
                if (temp_q >= int'(cfg_maxdeg) * 16) begin
                    switch_mode(htc_pkg::MODE_CODE_OVER);
                end else if (!run_q || tgt_q == 0) begin
                    switch_mode(htc_pkg::MODE_CODE_IDLE);
                end else begin
                    if (temp_q > target_x16() + int'(cfg_tol))
                        switch_mode(htc_pkg::MODE_CODE_IDLE);
                    case (mode_q)
                        htc_pkg::MODE_CODE_IDLE: begin
                            if (below_window())
                                switch_mode(htc_pkg::MODE_CODE_HEAT);
                            else if (within_window())
                                switch_mode(htc_pkg::MODE_CODE_REACH);
                        end
                        htc_pkg::MODE_CODE_HEAT: begin
                            if (within_window())
                                switch_mode(htc_pkg::MODE_CODE_STAB);
                        end
                        htc_pkg::MODE_CODE_STAB: begin
                            if (mode_ms >= cfg_dwell && within_window())
                                switch_mode(htc_pkg::MODE_CODE_REACH);
                            else if (below_window())
                                switch_mode(htc_pkg::MODE_CODE_HEAT);
                        end
                        htc_pkg::MODE_CODE_REACH: begin
                            if (below_window())
                                switch_mode(htc_pkg::MODE_CODE_HEAT);
                        end
                        htc_pkg::MODE_CODE_OVER: begin
                            if (temp_q < (int'(cfg_maxdeg) - int'(cfg_margin)) * 16) begin
                                if (within_window())
                                    switch_mode(htc_pkg::MODE_CODE_REACH);
                                else if (below_window())
                                    switch_mode(htc_pkg::MODE_CODE_HEAT);
                                else
                                    switch_mode(htc_pkg::MODE_CODE_IDLE);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            htc_pkg::CMD_TICK: begin
                if (mode_ms != htc_pkg::TIMER_MAX)
                    mode_ms = mode_ms + 1'b1;
            end
            default: ;
        endcase
        r.heater_on    = heat_q;
        r.servo_angle  = servo_q;
        r.mode         = mode_q;
        r.target_out   = tgt_q;
        r.entry_status = status;
        r.entering     = entry_q;
        return r;
    endfunction

    function automatic logic signed [TEMP_W-1:0] clamp_temp(input int t);
        if (t > 2047)
            t = 2047;
        else if (t < -2048)
            t = -2048;
        return TEMP_W'(t);
    endfunction

    // Offer one transaction after a random gap and record its expected outputs
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] key,
                             input logic signed [TEMP_W-1:0] smp, input logic sv);
        htc_pkg::item_t it;
        int gap;
        it.command      = cmd;
        it.key_code     = key;
        it.sample       = smp;
        it.sample_valid = sv;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_key_code     <= key;
        s_sample       <= smp;
        s_sample_valid <= sv;
        do @(posedge aclk); while (!s_ready);
        predicted_outputs.push_back(thermostat_step(it));
        items_sent++;
    endtask

    task automatic push_key(input logic [7:0] key);
        send_item(htc_pkg::CMD_KEY, key, TEMP_W'($urandom_range(0, 4095)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic push_sample(input logic signed [TEMP_W-1:0] t, input logic sv);
        send_item(htc_pkg::CMD_SAMPLE, 8'($urandom_range(0, 255)), t, sv);
    endtask

    task automatic push_tick();
        send_item(htc_pkg::CMD_TICK, 8'($urandom_range(0, 255)),
                  TEMP_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
    endtask

    // Key in a target as 'A', two or three digits, '#'
    task automatic enter_target(input int v, input bit three);
        push_key(htc_pkg::KEY_A);
        if (three || v >= 100)
            push_key(htc_pkg::KEY_0 + 8'(v / 100));
        push_key(htc_pkg::KEY_0 + 8'((v / 10) % 10));
        push_key(htc_pkg::KEY_0 + 8'(v % 10));
        push_key(htc_pkg::KEY_HASH);
    endtask

    // Stop offering input and wait until every result has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (predicted_outputs.size() != 0) @(posedge aclk);
    endtask

    // Write all five registers while the block is idle
    task automatic load_settings(input logic [7:0] tol, input logic [TIMER_W-1:0] dwell,
                                 input logic [DEG_W-1:0] maxd, input logic [4:0] margin,
                                 input logic [7:0] reheat);
        logic [CFG_IDX_W-1:0]  idx  [5];
        logic [CFG_DATA_W-1:0] vals [5];
        drain();
        idx  = '{htc_pkg::CFG_TOLERANCE, htc_pkg::CFG_DWELL, htc_pkg::CFG_MAX_DEG,
                 htc_pkg::CFG_MARGIN, htc_pkg::CFG_REHEAT};
        vals = '{CFG_DATA_W'(tol), dwell, CFG_DATA_W'(maxd), CFG_DATA_W'(margin),
                 CFG_DATA_W'(reheat)};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid  <= 1'b0;
        cfg_tol    = tol;
        cfg_dwell  = dwell;
        cfg_maxdeg = maxd;
        cfg_margin = margin;
        cfg_reheat = reheat;
    endtask

    // Keypad corner cases, sensor error and overheat at reset settings
    task automatic test_directed_cases();
        send_item(CMD_UNUSED, 8'hFF, 12'sh7FF, 1'b1);
        push_tick();
        push_key(8'hFF);
        push_key(htc_pkg::KEY_HASH);
        push_key(htc_pkg::KEY_0 + 8'd5);
        push_key(htc_pkg::KEY_A);
        push_key(htc_pkg::KEY_HASH);
        push_key(htc_pkg::KEY_0 + 8'd7);
        push_key(htc_pkg::KEY_HASH);
        push_key(htc_pkg::KEY_0);
        push_key(htc_pkg::KEY_0);
        push_key(htc_pkg::KEY_HASH);
        repeat (4) push_key(htc_pkg::KEY_9);
        push_key(htc_pkg::KEY_HASH);
        push_key(htc_pkg::KEY_0 + 8'd1);
        push_key(htc_pkg::KEY_0 + 8'd2);
        push_key(htc_pkg::KEY_0 + 8'd5);
        push_key(htc_pkg::KEY_HASH);
        push_sample(12'sh7FF, 1'b1);
        push_sample(12'sh800, 1'b0);
        push_sample(12'sh800, 1'b1);
        push_key(htc_pkg::KEY_C);
    endtask

    // Hold stabilizing through a short dwell, then reheat from reached
    task automatic test_dwell_expiry();
        int t16;
        t16 = 30 * 16;
        load_settings(htc_pkg::TOL_RST, 16'd12, htc_pkg::MAXDEG_RST, htc_pkg::MARGIN_RST,
                      htc_pkg::REHEAT_RST);
        no_idle = 1'b1;
        push_sample(clamp_temp(t16), 1'b1);
        enter_target(30, 1'b0);
        push_tick();
        push_sample(clamp_temp(t16), 1'b1);
        repeat (12) push_tick();
        push_sample(clamp_temp(t16), 1'b1);
        push_sample(clamp_temp(t16 - 20), 1'b1);
        push_key(htc_pkg::KEY_C);
        no_idle = 1'b0;
    endtask

    // Mixed traffic over several register settings, extremes included
    task automatic test_random_traffic();
        int start;
        int pick;
        int v;
        int span;
        int tick_max;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: load_settings(htc_pkg::TOL_RST, 16'd20, htc_pkg::MAXDEG_RST,
                                 htc_pkg::MARGIN_RST, htc_pkg::REHEAT_RST);
                1: load_settings(8'd0, 16'd0, 7'd1, 5'd0, 8'd0);
                2: load_settings(8'd255, htc_pkg::TIMER_MAX, 7'd125, 5'd31, 8'd255);
                default: load_settings(8'($urandom_range(0, 255)), 16'($urandom_range(0, 40)),
                                       7'($urandom_range(20, 125)), 5'($urandom_range(0, 31)),
                                       8'($urandom_range(0, 255)));
            endcase
            tick_max = (cfg_dwell <= 40) ? int'(cfg_dwell) / 3 + 2 : 3;
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                no_idle = ($urandom_range(0, 7) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    // valid target, then samples around it with ticks between
                    v = $urandom_range(1, int'(cfg_maxdeg));
                    enter_target(v, 1'($urandom_range(0, 1)));
                    span = int'(cfg_tol) + 48;
                    repeat ($urandom_range(3, 10)) begin
                        push_sample(clamp_temp(v * 16 + int'($urandom_range(0, 2 * span)) - span),
                                    1'($urandom_range(0, 7) != 0));
                        repeat ($urandom_range(0, tick_max)) push_tick();
                    end
                    if ($urandom_range(0, 5) == 0)
                        push_key(htc_pkg::KEY_C);
                end else if (pick < 65) begin
                    // swing around the overheat threshold and the recovery point
                    repeat ($urandom_range(3, 8)) begin
                        push_sample(clamp_temp(int'(cfg_maxdeg) * 16 + 40 -
                                    int'($urandom_range(0, int'(cfg_margin) * 16 + 120))),
                                    1'($urandom_range(0, 7) != 0));
                        if ($urandom_range(0, 1) == 1)
                            push_tick();
                    end
                end else if (pick < 80) begin
                    // broken entry: wrong digit count, bad value or abort
                    push_key(htc_pkg::KEY_A);
                    repeat ($urandom_range(0, 4))
                        push_key(htc_pkg::KEY_0 + 8'($urandom_range(0, 9)));
                    case ($urandom_range(0, 3))
                        0: push_key(htc_pkg::KEY_C);
                        1: push_key(8'($urandom_range(0, 255)));
                        default: push_key(htc_pkg::KEY_HASH);
                    endcase
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                  TEMP_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
                end
            end
            no_idle = 1'b0;
        end
    endtask

    // Result side: random stall before taking each result
    initial begin : result_sink
        int stall;
        wait (aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        htc_pkg::result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_outputs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: mode=%0d target=%0d", m_mode, m_target_out);
            end else begin
                exp_r = predicted_outputs.pop_front();
                if (m_heater_on != exp_r.heater_on || m_servo_angle != exp_r.servo_angle ||
                    m_mode != exp_r.mode || m_target_out != exp_r.target_out ||
                    m_entry_status != exp_r.entry_status || m_entering != exp_r.entering) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("expected heat=%0d servo=%0d mode=%0d tgt=%0d st=%0d ent=%0d",
                                 exp_r.heater_on, exp_r.servo_angle, exp_r.mode,
                                 exp_r.target_out, exp_r.entry_status, exp_r.entering);
                        $display("actual   heat=%0d servo=%0d mode=%0d tgt=%0d st=%0d ent=%0d",
                                 m_heater_on, m_servo_angle, m_mode, m_target_out,
                                 m_entry_status, m_entering);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no channel moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        thermostat_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_dwell_expiry();
        test_random_traffic();
        drain();
        repeat (8) @(posedge aclk);
        // count any result that never came back
        mismatch_count += predicted_outputs.size();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
